>>> rtl/core/tcw_pkg.sv
// Shared constants, codes and types of the text console writer.
// Used by tcw_cfg, tcw_engine and text_console_writer; depends on nothing else.
package tcw_pkg;

  // Screen store geometry.
  localparam int unsigned MAX_COLS = 128;
  localparam int unsigned MAX_ROWS = 64;
  localparam int unsigned CELLS    = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W   = $clog2(CELLS);
  // Cursor position can briefly reach one past the screen after a line feed.
  localparam int unsigned POS_W    = ADDR_W + 1;
  localparam int unsigned COLS_W   = $clog2(MAX_COLS + 1);
  localparam int unsigned ROWS_W   = $clog2(MAX_ROWS + 1);
  // Quotient bits of the row recompute after a column change.
  localparam int unsigned QBITS    = $clog2(MAX_ROWS);
  localparam int unsigned DIVK_W   = (QBITS > 1) ? $clog2(QBITS) : 1;

  // Field widths of the ports.
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned RROW_W     = 6;
  localparam int unsigned RCOL_W     = 7;
  localparam int unsigned CELL_W     = 16;
  localparam int unsigned ROW_OUT_W  = 6;
  localparam int unsigned COL_W      = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned COLS_CFG_W = 8;
  localparam int unsigned ROWS_CFG_W = 7;
  localparam int unsigned ATTR_W     = 8;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE = 2'd2;

  localparam logic [COLS_CFG_W-1:0] COLUMNS_RESET   = 8'd80;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET      = 7'd25;
  localparam logic [ATTR_W-1:0]     ATTRIBUTE_RESET = 8'h0F;

  // Character codes and cell constants.
  localparam logic [CHAR_W-1:0] CHR_BS   = 8'h08;
  localparam logic [CHAR_W-1:0] CHR_TAB  = 8'h09;
  localparam logic [CHAR_W-1:0] CHR_LF   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHR_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] SPACE    = 8'h20;
  localparam logic [ATTR_W-1:0] PUT_ATTR = 8'h0F;
  localparam logic [1:0]        TAB_LAST = 2'd3;  // four spaces, counted 3 down to 0

  // Cycles that inputs are held off after a configuration write.
  localparam logic [1:0] CFG_SETTLE = 2'd3;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_EXEC,
    ST_PUT,
    ST_LF,
    ST_SCROLL,
    ST_SCR_END,
    ST_CLEAR,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } state_e;

  // Geometry and settings derived from the configuration registers.
  typedef struct packed {
    logic [COLS_W-1:0] cols;
    logic [ROWS_W-1:0] rows;
    logic [ADDR_W-1:0] last;
    logic [ADDR_W-1:0] bottom;
    logic [ATTR_W-1:0] attr;
    logic              cols_wr;
    logic              busy;
  } geom_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_value;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_W-1:0]     cursor_col;
    logic                 scrolled;
  } result_t;

endpackage

>>> rtl/core/tcw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/core/tcw_cfg.sv
// Configuration registers of the text console writer and the screen geometry
// derived from them. Depends on tcw_pkg.
module tcw_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output tcw_pkg::geom_t                 geom_o
);
  import tcw_pkg::*;

  logic [COLS_CFG_W-1:0] columns_q;
  logic [ROWS_CFG_W-1:0] rows_q;
  logic [ATTR_W-1:0]     attr_q;
  logic [COLS_W-1:0]     eff_c_d, eff_c_q;
  logic [ROWS_W-1:0]     eff_r_d, eff_r_q;
  logic [POS_W-1:0]      total_q;
  logic [ADDR_W-1:0]     last_q, bottom_q;
  logic [1:0]            settle_q;
  logic                  wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i & cfg_ready_o;

  always_comb begin
    if (columns_q < COLS_CFG_W'(2)) begin
      eff_c_d = COLS_W'(2);
    end else if (COLS_W'(columns_q) > COLS_W'(MAX_COLS)) begin
      eff_c_d = COLS_W'(MAX_COLS);
    end else begin
      eff_c_d = COLS_W'(columns_q);
    end
    if (rows_q < ROWS_CFG_W'(2)) begin
      eff_r_d = ROWS_W'(2);
    end else if (ROWS_W'(rows_q) > ROWS_W'(MAX_ROWS)) begin
      eff_r_d = ROWS_W'(MAX_ROWS);
    end else begin
      eff_r_d = ROWS_W'(rows_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
      rows_q    <= ROWS_RESET;
      attr_q    <= ATTRIBUTE_RESET;
      settle_q  <= CFG_SETTLE;
      eff_c_q   <= COLS_W'(2);
      eff_r_q   <= ROWS_W'(2);
      total_q   <= POS_W'(4);
      last_q    <= ADDR_W'(3);
      bottom_q  <= ADDR_W'(2);
    end else begin
      if (wr) begin
        case (cfg_index_i)
          REG_COLUMNS:   columns_q <= cfg_data_i[COLS_CFG_W-1:0];
          REG_ROWS:      rows_q    <= cfg_data_i[ROWS_CFG_W-1:0];
          REG_ATTRIBUTE: attr_q    <= cfg_data_i[ATTR_W-1:0];
          default: ;
        endcase
        settle_q <= CFG_SETTLE;
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
      // Three register stages from the clamp to the last-cell and bottom-row marks.
      eff_c_q  <= eff_c_d;
      eff_r_q  <= eff_r_d;
      total_q  <= POS_W'(eff_c_q * eff_r_q);
      last_q   <= ADDR_W'(total_q - POS_W'(1));
      bottom_q <= ADDR_W'(total_q - POS_W'(eff_c_q));
    end
  end

  always_comb begin
    geom_o.cols    = eff_c_q;
    geom_o.rows    = eff_r_q;
    geom_o.last    = last_q;
    geom_o.bottom  = bottom_q;
    geom_o.attr    = attr_q;
    geom_o.cols_wr = wr && (cfg_index_i == REG_COLUMNS);
    geom_o.busy    = (settle_q != 2'd0) | cfg_valid_i;
  end

endmodule

>>> rtl/core/tcw_engine.sv
// Command sequencer of the text console writer: cursor state, reset zeroing, put,
// scroll and clear sweeps and reads over the screen RAM. Depends on tcw_pkg.
module tcw_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tcw_pkg::CMD_W-1:0]  cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::RROW_W-1:0] read_row_i,
  input  logic [tcw_pkg::RCOL_W-1:0] read_col_i,
  input  tcw_pkg::geom_t             geom_i,
  output tcw_pkg::mem_req_t          mem_o,
  input  logic [tcw_pkg::CELL_W-1:0] mem_rdata_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output tcw_pkg::result_t           res_o
);
  import tcw_pkg::*;

  state_e             state_q, state_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [ROWS_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [CMD_W-1:0]   cmd_q, cmd_d;
  logic [CHAR_W-1:0]  chr_q, chr_d;
  logic [RROW_W-1:0]  rrow_q, rrow_d;
  logic [RCOL_W-1:0]  rcol_q, rcol_d;
  logic [1:0]         tab_q, tab_d;
  logic               scrolled_q, scrolled_d;
  logic               ret_put_q, ret_put_d;
  logic               resync_q, resync_d;
  logic [POS_W-1:0]   ptr_q, ptr_d;
  logic               mv_valid_q, mv_valid_d;
  logic [POS_W-1:0]   mv_src_q, mv_src_d;
  logic [ADDR_W-1:0]  div_rem_q, div_rem_d;
  logic [DIVK_W-1:0]  div_k_q, div_k_d;
  logic [ADDR_W-1:0]  rd_addr_q, rd_addr_d;
  logic               rd_ok_q, rd_ok_d;
  logic [CELL_W-1:0]  value_q, value_d;

  logic [POS_W-1:0]   cols_w, last_w, mv_dst, div_sh, rd_sum, bs_pos;
  logic [ADDR_W-1:0]  div_rem_new;
  logic               div_ge, accept;

  assign cols_w  = POS_W'(geom_i.cols);
  assign last_w  = POS_W'(geom_i.last);
  assign mv_dst  = mv_src_q - cols_w;
  assign div_sh  = cols_w << div_k_q;
  assign div_ge  = POS_W'(div_rem_q) >= div_sh;
  assign div_rem_new = div_ge ? (div_rem_q - div_sh[ADDR_W-1:0]) : div_rem_q;
  assign rd_sum  = POS_W'(POS_W'(rrow_q) * cols_w) + POS_W'(rcol_q);
  assign bs_pos  = (pos_q != '0) ? (pos_q - POS_W'(1)) : pos_q;

  assign in_ready_o = (state_q == ST_IDLE) && !geom_i.busy;
  assign accept     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      pos_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      cmd_q      <= '0;
      chr_q      <= '0;
      rrow_q     <= '0;
      rcol_q     <= '0;
      tab_q      <= '0;
      scrolled_q <= 1'b0;
      ret_put_q  <= 1'b0;
      resync_q   <= 1'b0;
      ptr_q      <= '0;
      mv_valid_q <= 1'b0;
      mv_src_q   <= '0;
      div_rem_q  <= '0;
      div_k_q    <= '0;
      rd_addr_q  <= '0;
      rd_ok_q    <= 1'b0;
      value_q    <= '0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      row_q      <= row_d;
      col_q      <= col_d;
      cmd_q      <= cmd_d;
      chr_q      <= chr_d;
      rrow_q     <= rrow_d;
      rcol_q     <= rcol_d;
      tab_q      <= tab_d;
      scrolled_q <= scrolled_d;
      ret_put_q  <= ret_put_d;
      resync_q   <= resync_d;
      ptr_q      <= ptr_d;
      mv_valid_q <= mv_valid_d;
      mv_src_q   <= mv_src_d;
      div_rem_q  <= div_rem_d;
      div_k_q    <= div_k_d;
      rd_addr_q  <= rd_addr_d;
      rd_ok_q    <= rd_ok_d;
      value_q    <= value_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    row_d      = row_q;
    col_d      = col_q;
    cmd_d      = cmd_q;
    chr_d      = chr_q;
    rrow_d     = rrow_q;
    rcol_d     = rcol_q;
    tab_d      = tab_q;
    scrolled_d = scrolled_q;
    ret_put_d  = ret_put_q;
    resync_d   = resync_q | geom_i.cols_wr;
    ptr_d      = ptr_q;
    mv_valid_d = 1'b0;
    mv_src_d   = mv_src_q;
    div_rem_d  = div_rem_q;
    div_k_d    = div_k_q;
    rd_addr_d  = rd_addr_q;
    rd_ok_d    = rd_ok_q;
    value_d    = value_q;
    res_valid_o = 1'b0;

    mem_o.we    = 1'b0;
    mem_o.waddr = pos_q[ADDR_W-1:0];
    mem_o.wdata = {PUT_ATTR, chr_q};
    mem_o.raddr = rd_addr_q;

    // The trailing write of a scroll move lands in the cycle after its read.
    if (mv_valid_q) begin
      mem_o.we    = 1'b1;
      mem_o.waddr = mv_dst[ADDR_W-1:0];
      mem_o.wdata = (mv_src_q <= last_w) ? mem_rdata_i : '0;
    end

    case (state_q)
      ST_INIT: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = ptr_q[ADDR_W-1:0];
        mem_o.wdata = '0;
        if (ptr_q == POS_W'(CELLS - 1)) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_q + POS_W'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cmd_d      = cmd_i;
          chr_d      = char_code_i;
          rrow_d     = read_row_i;
          rcol_d     = read_col_i;
          scrolled_d = 1'b0;
          value_d    = '0;
          state_d    = ST_START;
        end
      end

      ST_START: begin
        if (pos_q > last_w) begin
          // Cursor left outside a shrunken screen: park it on the bottom row.
          pos_d    = POS_W'(geom_i.bottom);
          row_d    = geom_i.rows - ROWS_W'(1);
          col_d    = '0;
          resync_d = 1'b0;
          state_d  = ST_EXEC;
        end else if (resync_q) begin
          div_rem_d = pos_q[ADDR_W-1:0];
          div_k_d   = DIVK_W'(QBITS - 1);
          row_d     = '0;
          state_d   = ST_DIV;
        end else begin
          state_d = ST_EXEC;
        end
      end

      ST_DIV: begin
        // One quotient bit per cycle: row and column of the linear cursor.
        div_rem_d = div_rem_new;
        row_d     = {row_q[ROWS_W-2:0], div_ge};
        if (div_k_q == '0) begin
          col_d    = div_rem_new[COL_W-1:0];
          resync_d = 1'b0;
          state_d  = ST_EXEC;
        end else begin
          div_k_d = div_k_q - DIVK_W'(1);
        end
      end

      ST_EXEC: begin
        case (cmd_q)
          CMD_PUT: begin
            case (chr_q)
              CHR_TAB: begin
                tab_d   = TAB_LAST;
                chr_d   = SPACE;
                state_d = ST_PUT;
              end
              CHR_LF: begin
                pos_d   = pos_q - POS_W'(col_q) + cols_w;
                row_d   = row_q + ROWS_W'(1);
                col_d   = '0;
                state_d = ST_LF;
              end
              CHR_CR: begin
                pos_d   = pos_q - POS_W'(col_q);
                col_d   = '0;
                state_d = ST_DONE;
              end
              CHR_BS: begin
                mem_o.we    = 1'b1;
                mem_o.waddr = bs_pos[ADDR_W-1:0];
                mem_o.wdata = {PUT_ATTR, SPACE};
                pos_d       = bs_pos;
                if (pos_q != '0) begin
                  if (col_q == '0) begin
                    col_d = COL_W'(geom_i.cols - COLS_W'(1));
                    row_d = row_q - ROWS_W'(1);
                  end else begin
                    col_d = col_q - COL_W'(1);
                  end
                end
                state_d = ST_DONE;
              end
              default: begin
                tab_d   = '0;
                state_d = ST_PUT;
              end
            endcase
          end
          CMD_CLEAR: begin
            ptr_d   = '0;
            state_d = ST_CLEAR;
          end
          CMD_READ: begin
            rd_addr_d = rd_sum[ADDR_W-1:0];
            rd_ok_d   = (ROWS_W'(rrow_q) < geom_i.rows) && (COLS_W'(rcol_q) < geom_i.cols);
            state_d   = ST_READ;
          end
          default: state_d = ST_DONE;
        endcase
      end

      ST_PUT: begin
        if (pos_q >= last_w) begin
          ret_put_d = 1'b1;
          ptr_d     = cols_w;
          state_d   = ST_SCROLL;
        end else begin
          mem_o.we    = 1'b1;
          mem_o.waddr = pos_q[ADDR_W-1:0];
          mem_o.wdata = {PUT_ATTR, chr_q};
          pos_d       = pos_q + POS_W'(1);
          if (COLS_W'(col_q) + COLS_W'(1) == geom_i.cols) begin
            col_d = '0;
            row_d = row_q + ROWS_W'(1);
          end else begin
            col_d = col_q + COL_W'(1);
          end
          if (tab_q != 2'd0) begin
            tab_d = tab_q - 2'd1;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      ST_LF: begin
        if (pos_q >= last_w) begin
          ret_put_d = 1'b0;
          ptr_d     = cols_w;
          state_d   = ST_SCROLL;
        end else begin
          state_d = ST_DONE;
        end
      end

      ST_SCROLL: begin
        // Read source cell, write it one row up next cycle; sources past the
        // last cell turn into zero writes that clear the bottom row.
        mem_o.raddr = ptr_q[ADDR_W-1:0];
        mv_valid_d  = 1'b1;
        mv_src_d    = ptr_q;
        if (ptr_q == last_w + cols_w) begin
          state_d = ST_SCR_END;
        end else begin
          ptr_d = ptr_q + POS_W'(1);
        end
      end

      ST_SCR_END: begin
        pos_d      = POS_W'(geom_i.bottom);
        row_d      = geom_i.rows - ROWS_W'(1);
        col_d      = '0;
        scrolled_d = 1'b1;
        state_d    = ret_put_q ? ST_PUT : ST_DONE;
      end

      ST_CLEAR: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = ptr_q[ADDR_W-1:0];
        mem_o.wdata = {geom_i.attr, SPACE};
        if (ptr_q == last_w) begin
          state_d = ST_DONE;
        end else begin
          ptr_d = ptr_q + POS_W'(1);
        end
      end

      ST_READ: begin
        mem_o.raddr = rd_addr_q;
        state_d     = ST_RDATA;
      end

      ST_RDATA: begin
        value_d = rd_ok_q ? mem_rdata_i : '0;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_o.cell_value = value_q;
    res_o.cursor_row = row_q[ROW_OUT_W-1:0];
    res_o.cursor_col = col_q;
    res_o.scrolled   = scrolled_q;
  end

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_o.we)
    else $error("screen RAM written while idle");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_START))
    else $error("accepted request did not start");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (row_q < geom_i.rows))
    else $error("cursor row outside the screen at result");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (COLS_W'(col_q) < geom_i.cols))
    else $error("cursor column outside the screen at result");

  a_scroll_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCR_END) |-> mv_valid_q)
    else $error("scroll ended without its final move write");

endmodule

>>> rtl/core/text_console_writer.sv
// Top level of the text console writer: configuration block, command engine,
// screen RAM and result register. Depends on tcw_pkg, tcw_cfg, tcw_engine, tcw_ram.
//
// Usage: requests enter on the in channel (cmd, char_code, read_row, read_col)
// and each request yields exactly one result on the out channel (cell_value,
// cursor_row, cursor_col, scrolled). The cfg channel writes columns (index 0),
// rows (index 1) and attribute (index 2); it is always ready, and no request is
// accepted after a write while the geometry settles. One request is processed
// at a time: the next request is accepted only once the current one has handed
// over its result. A scroll walks the screen RAM one cell a cycle, and a clear
// rewrites all columns*rows cells. The first request after a columns write
// recomputes the cursor row and column, one quotient bit a cycle, unless the
// cursor has fallen off the screen.
// After reset the block zeroes all 8192 RAM cells, one a cycle, with in_ready
// low; configuration writes are taken during that pass.
// The result register decouples the sides: a new request is accepted while a
// result still waits, and the engine holds its next result until the register
// frees up when the receiver stalls.
module text_console_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [tcw_pkg::CMD_W-1:0]         cmd_i,
  input  logic [tcw_pkg::CHAR_W-1:0]        char_code_i,
  input  logic [tcw_pkg::RROW_W-1:0]        read_row_i,
  input  logic [tcw_pkg::RCOL_W-1:0]        read_col_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tcw_pkg::CELL_W-1:0]        cell_value_o,
  output logic [tcw_pkg::ROW_OUT_W-1:0]     cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]         cursor_col_o,
  output logic                              scrolled_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tcw_pkg::*;

  geom_t             geom;
  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rdata;
  result_t           res, out_q;
  logic              res_valid, res_ready, out_valid_q;

  tcw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  tcw_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .geom_i      (geom),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  tcw_ram #(
    .DEPTH (CELLS),
    .WIDTH (CELL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = out_q.cell_value;
  assign cursor_row_o = out_q.cursor_row;
  assign cursor_col_o = out_q.cursor_col;
  assign scrolled_o   = out_q.scrolled;

endmodule
